### hw/rtl/amf_pkg.sv
// amf_pkg: shared constants, payload types, register map and controller interface
// for the adaptive median filter. No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package amf_pkg;

  localparam int MAX_WINDOW = 7;
  localparam int MAX_WIDTH  = 1024;

  localparam int RAD    = MAX_WINDOW / 2;
  localparam int LINES  = 2 * RAD + 2;
  localparam int NSIDE  = 2 * RAD + 1;
  localparam int NCELL  = NSIDE * NSIDE;
  localparam int NSIZE  = RAD;
  localparam int CENTRE = (NCELL - 1) / 2;

  localparam int PIX_W  = 8;
  localparam int MW_W   = 3;
  localparam int WID_W  = 11;
  localparam int ROW_W  = 16;
  localparam int CMP_W  = 19;
  localparam int COL_W  = $clog2(MAX_WIDTH);
  localparam int SLOT_W = $clog2(LINES);
  localparam int K_W    = $clog2(NSIDE);
  localparam int CELL_W = $clog2(NCELL);
  localparam int CNT_W  = $clog2(NCELL + 1);
  localparam int SZ_W   = (NSIZE > 1) ? $clog2(NSIZE) : 1;
  localparam int BIT_W  = $clog2(PIX_W);

  localparam int ADDR_W = 4;
  localparam int DATA_W = 32;

  localparam logic [PIX_W-1:0] PIX_TOP = {1'b1, {(PIX_W-1){1'b0}}};

  // register indexes, byte address is 4 * index
  localparam logic [1:0] REG_MAX_WINDOW   = 2'd0;
  localparam logic [1:0] REG_IMAGE_WIDTH  = 2'd1;
  localparam logic [1:0] REG_IMAGE_HEIGHT = 2'd2;

  localparam logic [MW_W-1:0]  RST_MAX_WINDOW   = 3'd7;
  localparam logic [WID_W-1:0] RST_IMAGE_WIDTH  = 11'd1024;
  localparam logic [ROW_W-1:0] RST_IMAGE_HEIGHT = 16'd480;

  localparam logic OP_PIXEL = 1'b0;
  localparam logic OP_FLUSH = 1'b1;

  typedef struct packed {
    logic             opcode;
    logic [PIX_W-1:0] pixel_in;
  } amf_in_t;

  typedef struct packed {
    logic [PIX_W-1:0] pixel_out;
    logic             frame_last;
  } amf_out_t;

  typedef struct packed {
    logic [MW_W-1:0]  max_window;
    logic [WID_W-1:0] image_width;
    logic [ROW_W-1:0] image_height;
  } amf_cfg_t;

  typedef enum logic [7:0] {
    ST_CLEAR = 8'b0000_0001,
    ST_IDLE  = 8'b0000_0010,
    ST_CHECK = 8'b0000_0100,
    ST_LOAD  = 8'b0000_1000,
    ST_TAIL  = 8'b0001_0000,
    ST_MED   = 8'b0010_0000,
    ST_EVAL  = 8'b0100_0000,
    ST_OUT   = 8'b1000_0000
  } amf_state_e;

  typedef struct packed {
    logic clr_en;
    logic accept;
    logic load_init;
    logic load_issue;
    logic med_init;
    logic med_step;
    logic eval_next;
    logic eval_done;
    logic out_load;
  } amf_cmd_t;

  typedef struct packed {
    logic clr_last;
    logic ready;
    logic load_last;
    logic bit_last;
    logic done;
    logic out_busy;
  } amf_sts_t;

  // window cell e lies inside the square of side 2*t+3 around the centre
  function automatic logic cell_in(int e, int t);
    int di;
    int dj;
    di = e / NSIDE - RAD;
    dj = e % NSIDE - RAD;
    if (di < 0) di = -di;
    if (dj < 0) dj = -dj;
    return (di <= t + 1) && (dj <= t + 1);
  endfunction

  // median rank of the square of side 2*t+3
  function automatic int med_rank(int t);
    int s;
    s = 2 * t + 3;
    return (s * s - 1) / 2;
  endfunction

endpackage
`default_nettype wire

### hw/rtl/amf_ctrl.sv
// amf_ctrl: sequencing state machine of the adaptive median filter.
// Depends on amf_pkg for state codes and the command / status structs.
`timescale 1ns / 1ps
`default_nettype none
module amf_ctrl import amf_pkg::*; (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     in_valid_i,
  output logic          in_stall_o,
  input  wire amf_sts_t sts_i,
  output amf_cmd_t      cmd_o
);

  amf_state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      ST_CLEAR: begin
        cmd_o.clr_en = 1'b1;
        if (sts_i.clr_last) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          state_d      = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (sts_i.ready) begin
          cmd_o.load_init = 1'b1;
          state_d         = ST_LOAD;
        end else begin
          state_d = ST_IDLE;
        end
      end
      ST_LOAD: begin
        cmd_o.load_issue = 1'b1;
        if (sts_i.load_last) state_d = ST_TAIL;
      end
      ST_TAIL: begin
        cmd_o.med_init = 1'b1;
        state_d        = ST_MED;
      end
      ST_MED: begin
        cmd_o.med_step = 1'b1;
        if (sts_i.bit_last) state_d = ST_EVAL;
      end
      ST_EVAL: begin
        if (sts_i.done) begin
          cmd_o.eval_done = 1'b1;
          state_d         = ST_OUT;
        end else begin
          cmd_o.eval_next = 1'b1;
          state_d         = ST_MED;
        end
      end
      ST_OUT: begin
        if (!sts_i.out_busy) begin
          cmd_o.out_load = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: state_d = ST_CLEAR;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= ST_CLEAR;
    else state_q <= state_d;
  end

  assign in_stall_o = (state_q != ST_IDLE);

endmodule
`default_nettype wire

### hw/rtl/amf_dpath.sv
// amf_dpath: raster counters, line store, window registers, running min / max
// and bit-serial rank select. Depends on amf_pkg; driven by amf_ctrl commands.
`timescale 1ns / 1ps
`default_nettype none
module amf_dpath import amf_pkg::*; (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire amf_cfg_t cfg_i,
  input  wire amf_in_t  in_data_i,
  input  wire amf_cmd_t cmd_i,
  output amf_sts_t      sts_o,
  output logic          out_valid_o,
  input  wire logic     out_stall_i,
  output amf_out_t      out_data_o
);

  // effective geometry
  logic [WID_W-1:0] w_eff;
  logic [ROW_W-1:0] h_eff;
  logic [3:0]       mw_eff;
  logic [SZ_W-1:0]  sz_last;

  always_comb begin
    if (cfg_i.image_width == '0) w_eff = WID_W'(1);
    else if (int'(cfg_i.image_width) > MAX_WIDTH) w_eff = WID_W'(MAX_WIDTH);
    else w_eff = cfg_i.image_width;
    h_eff = (cfg_i.image_height == '0) ? ROW_W'(1) : cfg_i.image_height;
    if (cfg_i.max_window < 3'd3) mw_eff = 4'd3;
    else if (int'(cfg_i.max_window) > MAX_WINDOW) mw_eff = 4'(MAX_WINDOW);
    else mw_eff = {1'b0, cfg_i.max_window};
    // even sides fall to the odd side below through the shift
    sz_last = SZ_W'((mw_eff - 4'd3) >> 1);
  end

  logic [CMP_W-1:0] w_x, h_x;
  assign w_x = CMP_W'(w_eff);
  assign h_x = CMP_W'(h_eff);

  // raster counters
  logic [COL_W-1:0]  in_col_q, out_col_q;
  logic [ROW_W-1:0]  in_row_q, out_row_q;
  logic [SLOT_W-1:0] in_slot_q, out_slot_q;
  logic [COL_W-1:0]  clr_col_q;
  logic [SLOT_W-1:0] clr_slot_q;

  logic take_pix, in_wrap, out_wrap, frame_last;
  assign take_pix   = cmd_i.accept && (in_data_i.opcode == OP_PIXEL) && (in_row_q < h_eff);
  assign in_wrap    = (CMP_W'(in_col_q) + CMP_W'(1)) >= w_x;
  assign out_wrap   = (CMP_W'(out_col_q) + CMP_W'(1)) >= w_x;
  assign frame_last = ((CMP_W'(out_row_q) + CMP_W'(1)) >= h_x) && out_wrap;

  function automatic logic [SLOT_W-1:0] slot_inc(logic [SLOT_W-1:0] s);
    return (s == SLOT_W'(LINES - 1)) ? '0 : s + 1'b1;
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_col_q   <= '0;
      in_row_q   <= '0;
      in_slot_q  <= '0;
      out_col_q  <= '0;
      out_row_q  <= '0;
      out_slot_q <= '0;
      clr_col_q  <= '0;
      clr_slot_q <= '0;
    end else begin
      if (cmd_i.clr_en) begin
        if (clr_col_q == COL_W'(MAX_WIDTH - 1)) begin
          clr_col_q  <= '0;
          clr_slot_q <= slot_inc(clr_slot_q);
        end else begin
          clr_col_q <= clr_col_q + 1'b1;
        end
      end
      if (take_pix) begin
        if (in_wrap) begin
          in_col_q  <= '0;
          in_row_q  <= in_row_q + 1'b1;
          in_slot_q <= slot_inc(in_slot_q);
        end else begin
          in_col_q <= in_col_q + 1'b1;
        end
      end
      if (cmd_i.out_load) begin
        if (frame_last) begin
          in_col_q   <= '0;
          in_row_q   <= '0;
          in_slot_q  <= '0;
          out_col_q  <= '0;
          out_row_q  <= '0;
          out_slot_q <= '0;
        end else if (out_wrap) begin
          out_col_q  <= '0;
          out_row_q  <= out_row_q + 1'b1;
          out_slot_q <= slot_inc(out_slot_q);
        end else begin
          out_col_q <= out_col_q + 1'b1;
        end
      end
    end
  end

  // output readiness: bottom-right neighbor (clipped) has arrived
  logic [CMP_W-1:0] nr, nc;
  always_comb begin
    nr = CMP_W'(out_row_q) + CMP_W'(RAD);
    if (nr > h_x - CMP_W'(1)) nr = h_x - CMP_W'(1);
    nc = CMP_W'(out_col_q) + CMP_W'(RAD);
    if (nc > w_x - CMP_W'(1)) nc = w_x - CMP_W'(1);
  end

  assign sts_o.ready = (in_row_q >= h_eff) || (CMP_W'(in_row_q) > nr) ||
                       ((CMP_W'(in_row_q) == nr) && (CMP_W'(in_col_q) > nc));
  assign sts_o.clr_last = (clr_slot_q == SLOT_W'(LINES - 1)) &&
                          (clr_col_q == COL_W'(MAX_WIDTH - 1));

  // window gather counters
  logic [K_W-1:0]    ki_q, kj_q, ki1_q, kj1_q;
  logic [CELL_W-1:0] cell_q, cell1_q;
  logic              ld_v_q, inimg1_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ki_q   <= '0;
      kj_q   <= '0;
      cell_q <= '0;
      ld_v_q <= 1'b0;
    end else begin
      ld_v_q <= cmd_i.load_issue;
      if (cmd_i.load_init) begin
        ki_q   <= '0;
        kj_q   <= '0;
        cell_q <= '0;
      end else if (cmd_i.load_issue) begin
        cell_q <= cell_q + 1'b1;
        if (kj_q == K_W'(NSIDE - 1)) begin
          kj_q <= '0;
          ki_q <= ki_q + 1'b1;
        end else begin
          kj_q <= kj_q + 1'b1;
        end
      end
    end
  end

  assign sts_o.load_last = (cell_q == CELL_W'(NCELL - 1));

  // neighbor position and its line store slot
  logic [CMP_W-1:0]  rr, cc;
  logic              inimg;
  logic [SLOT_W+1:0] st;
  logic [SLOT_W-1:0] rd_slot;
  logic [COL_W-1:0]  rd_col;

  always_comb begin
    rr    = CMP_W'(out_row_q) + CMP_W'(ki_q) - CMP_W'(RAD);
    cc    = CMP_W'(out_col_q) + CMP_W'(kj_q) - CMP_W'(RAD);
    // negative offsets wrap to the top half, which is never below the bounds
    inimg = (rr < h_x) && (cc < w_x);
    st    = (SLOT_W+2)'(out_slot_q) + (SLOT_W+2)'(ki_q) + (SLOT_W+2)'(LINES - RAD);
    if (st >= (SLOT_W+2)'(2 * LINES)) st = st - (SLOT_W+2)'(2 * LINES);
    else if (st >= (SLOT_W+2)'(LINES)) st = st - (SLOT_W+2)'(LINES);
    rd_slot = st[SLOT_W-1:0];
    rd_col  = inimg ? cc[COL_W-1:0] : '0;
  end

  // line store, one write or one read a cycle
  logic [PIX_W-1:0]  mem_q [LINES][MAX_WIDTH];
  logic [PIX_W-1:0]  rd_q;
  logic              we;
  logic [SLOT_W-1:0] wr_slot;
  logic [COL_W-1:0]  wr_col;
  logic [PIX_W-1:0]  wr_pix;

  assign we      = cmd_i.clr_en || take_pix;
  assign wr_slot = cmd_i.clr_en ? clr_slot_q : in_slot_q;
  assign wr_col  = cmd_i.clr_en ? clr_col_q : in_col_q;
  assign wr_pix  = cmd_i.clr_en ? '0 : in_data_i.pixel_in;

  always_ff @(posedge clk_i) begin
    if (we) mem_q[wr_slot][wr_col] <= wr_pix;
    if (cmd_i.load_issue) rd_q <= mem_q[rd_slot][rd_col];
  end

  always_ff @(posedge clk_i) begin
    ki1_q    <= ki_q;
    kj1_q    <= kj_q;
    cell1_q  <= cell_q;
    inimg1_q <= inimg;
  end

  // window registers and per-size min / max
  logic [PIX_W-1:0] wreg_q [NCELL];
  logic [PIX_W-1:0] min_q [NSIZE];
  logic [PIX_W-1:0] max_q [NSIZE];
  logic [PIX_W-1:0] wv;
  logic [K_W-1:0]   dki, dkj;

  assign wv  = inimg1_q ? rd_q : '0;
  assign dki = (ki1_q >= K_W'(RAD)) ? ki1_q - K_W'(RAD) : K_W'(RAD) - ki1_q;
  assign dkj = (kj1_q >= K_W'(RAD)) ? kj1_q - K_W'(RAD) : K_W'(RAD) - kj1_q;

  always_ff @(posedge clk_i) begin
    if (ld_v_q) wreg_q[cell1_q] <= wv;
    for (int t = 0; t < NSIZE; t++) begin
      if (cmd_i.load_init) begin
        min_q[t] <= '1;
        max_q[t] <= '0;
      end else if (ld_v_q && (dki <= K_W'(t + 1)) && (dkj <= K_W'(t + 1))) begin
        if (wv < min_q[t]) min_q[t] <= wv;
        if (wv > max_q[t]) max_q[t] <= wv;
      end
    end
  end

  // rank select, one result bit a cycle from the top
  logic [SZ_W-1:0]  sz_q;
  logic [BIT_W-1:0] bcnt_q;
  logic [PIX_W-1:0] r_q, thr;
  logic [CNT_W-1:0] cnt, rank;
  logic [NCELL-1:0] msk;

  always_comb begin
    msk  = '0;
    rank = '0;
    for (int s = 0; s < NSIZE; s++) begin
      if (sz_q == SZ_W'(s)) begin
        rank = CNT_W'(med_rank(s));
        for (int e = 0; e < NCELL; e++) msk[e] = cell_in(e, s);
      end
    end
    thr = r_q | (PIX_TOP >> bcnt_q);
    cnt = '0;
    for (int e = 0; e < NCELL; e++) begin
      if (msk[e] && (wreg_q[e] < thr)) cnt = cnt + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sz_q   <= '0;
      bcnt_q <= '0;
    end else if (cmd_i.med_init) begin
      sz_q   <= '0;
      bcnt_q <= '0;
    end else if (cmd_i.eval_next) begin
      sz_q   <= sz_q + 1'b1;
      bcnt_q <= '0;
    end else if (cmd_i.med_step) begin
      bcnt_q <= bcnt_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.med_init || cmd_i.eval_next) r_q <= '0;
    else if (cmd_i.med_step && (cnt <= rank)) r_q <= thr;
  end

  assign sts_o.bit_last = (bcnt_q == BIT_W'(PIX_W - 1));

  // level test
  logic [PIX_W-1:0] zmin, zmax, ctr, res;
  logic             pass;

  always_comb begin
    zmin = min_q[sz_q];
    zmax = max_q[sz_q];
    ctr  = wreg_q[CENTRE];
    pass = (zmin < r_q) && (r_q < zmax);
    if (pass && (zmin < ctr) && (ctr < zmax)) res = ctr;
    else res = r_q;
  end

  assign sts_o.done = pass || (sz_q == sz_last);

  logic [PIX_W-1:0] res_q;
  always_ff @(posedge clk_i) begin
    if (cmd_i.eval_done) res_q <= res;
  end

  // output register
  logic out_valid_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) out_valid_q <= 1'b0;
    else if (cmd_i.out_load) out_valid_q <= 1'b1;
    else if (!out_stall_i) out_valid_q <= 1'b0;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_data_o.pixel_out  <= res_q;
      out_data_o.frame_last <= frame_last;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign sts_o.out_busy = out_valid_q && out_stall_i;

endmodule
`default_nettype wire

### hw/rtl/adaptive_median_filter_core.sv
// adaptive median filter, top level: register port, controller and datapath.
// sequence: a beat with no output due returns to idle after the readiness check; otherwise
//   the 49 window cells are gathered in turn through the single line store port, then rank
//   select and the level test run for each window size tried (1..3 sizes).
// throughput: one beat in flight; next beat is taken the cycle after its result is registered.
// reset: async active low; then a pass that clears all 8192 line store entries, input stalled.
`timescale 1ns / 1ps
`default_nettype none
module adaptive_median_filter_core import amf_pkg::*; (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_stall_o,
  input  wire amf_in_t           in_data_i,
  output logic                   out_valid_o,
  input  wire logic              out_stall_i,
  output amf_out_t               out_data_o,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [ADDR_W-1:0] paddr,
  input  wire logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0]      prdata,
  output logic                   pready
);

  amf_cfg_t cfg_q;
  logic     wr_en;
  logic [1:0] reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite && pready;
  assign reg_idx = paddr[3:2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.max_window   <= RST_MAX_WINDOW;
      cfg_q.image_width  <= RST_IMAGE_WIDTH;
      cfg_q.image_height <= RST_IMAGE_HEIGHT;
    end else if (wr_en) begin
      case (reg_idx)
        REG_MAX_WINDOW:   cfg_q.max_window   <= pwdata[MW_W-1:0];
        REG_IMAGE_WIDTH:  cfg_q.image_width  <= pwdata[WID_W-1:0];
        REG_IMAGE_HEIGHT: cfg_q.image_height <= pwdata[ROW_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_MAX_WINDOW:   prdata = DATA_W'(cfg_q.max_window);
      REG_IMAGE_WIDTH:  prdata = DATA_W'(cfg_q.image_width);
      REG_IMAGE_HEIGHT: prdata = DATA_W'(cfg_q.image_height);
      default:          prdata = '0;
    endcase
  end

  amf_cmd_t cmd;
  amf_sts_t sts;

  amf_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  amf_dpath u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .in_data_i   (in_data_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule
`default_nettype wire

### hw/rtl/amf_chk.sv
// amf_chk: port-level checks for adaptive_median_filter_core, bound to the top level.
// Depends on amf_pkg for the payload types.
`timescale 1ns / 1ps
`default_nettype none
module amf_chk import amf_pkg::*; (
  input wire logic              clk_i,
  input wire logic              rst_ni,
  input wire logic              in_valid_i,
  input wire logic              in_stall_o,
  input wire amf_in_t           in_data_i,
  input wire logic              out_valid_o,
  input wire logic              out_stall_i,
  input wire amf_out_t          out_data_o,
  input wire logic              psel,
  input wire logic              penable,
  input wire logic              pwrite,
  input wire logic [ADDR_W-1:0] paddr,
  input wire logic [DATA_W-1:0] pwdata,
  input wire logic [DATA_W-1:0] prdata,
  input wire logic              pready
);

  // a result beat holds while stalled
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("output beat dropped under stall");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(out_data_o))
    else $error("output payload changed under stall");

  // the block is busy the cycle after it takes a beat
  a_busy_after_take: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input taken twice in a row");

  // a new result only appears while the input side is busy
  a_result_from_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_stall_o))
    else $error("result appeared without work in progress");

endmodule

bind adaptive_median_filter_core amf_chk u_chk (.*);
`default_nettype wire

### dv/tb_adaptive_median_filter_core.sv
// tb_adaptive_median_filter_core: self-checking bench for the adaptive median filter core;
// directed table, then random frames checked against an in-bench median predictor.
// depends on amf_pkg and adaptive_median_filter_core.
`timescale 1ns / 1ps
module tb_adaptive_median_filter_core;
  import amf_pkg::*;

  localparam int NUM_BEATS   = 650;
  localparam int QUIET_AFTER = 560;
  localparam int IDLE_LIMIT  = 50000;
  localparam int HOLD_CYCLES = 400;
  localparam int DRAIN_WAIT  = 100;

  typedef enum logic { ROW_CFG, ROW_BEAT } row_kind_e;
  typedef enum logic [1:0] { CHK_NONE, CHK_GIVEN, CHK_MODEL } chk_e;

  typedef struct packed {
    row_kind_e        kind;
    logic [1:0]       reg_idx;
    logic [31:0]      reg_val;
    logic             op;
    logic [PIX_W-1:0] pix;
    chk_e             chk;
    logic [PIX_W-1:0] exp_pix;
    logic             exp_last;
  } dir_row_t;

  localparam int DIR_ROWS = 29;
  dir_row_t dir_tab [DIR_ROWS] = '{
    '{ROW_BEAT, REG_MAX_WINDOW,   32'd0,    OP_FLUSH, 8'h00, CHK_NONE,  8'h00, 1'b0},
    '{ROW_BEAT, REG_MAX_WINDOW,   32'd0,    OP_PIXEL, 8'hA5, CHK_NONE,  8'h00, 1'b0},
    // one pixel frame, window register below range
    '{ROW_CFG,  REG_MAX_WINDOW,   32'd0,    OP_PIXEL, 8'h00, CHK_NONE,  8'h00, 1'b0},
    '{ROW_CFG,  REG_IMAGE_WIDTH,  32'd0,    OP_PIXEL, 8'h00, CHK_NONE,  8'h00, 1'b0},
    '{ROW_CFG,  REG_IMAGE_HEIGHT, 32'd0,    OP_PIXEL, 8'h00, CHK_NONE,  8'h00, 1'b0},
    '{ROW_BEAT, REG_MAX_WINDOW,   32'd0,    OP_PIXEL, 8'hFF, CHK_MODEL, 8'h00, 1'b0},
    '{ROW_BEAT, REG_MAX_WINDOW,   32'd0,    OP_PIXEL, 8'h00, CHK_GIVEN, 8'h00, 1'b1},
    '{ROW_BEAT, REG_MAX_WINDOW,   32'd0,    OP_PIXEL, 8'hFF, CHK_GIVEN, 8'h00, 1'b1},
    '{ROW_BEAT, REG_MAX_WINDOW,   32'd0,    OP_FLUSH, 8'h00, CHK_NONE,  8'h00, 1'b0},
    '{ROW_BEAT, REG_MAX_WINDOW,   32'd0,    OP_PIXEL, 8'h80, CHK_GIVEN, 8'h00, 1'b1},
    // 2x2 frame, even window register
    '{ROW_CFG,  REG_MAX_WINDOW,   32'd6,    OP_PIXEL, 8'h00, CHK_NONE,  8'h00, 1'b0},
    '{ROW_CFG,  REG_IMAGE_WIDTH,  32'd2,    OP_PIXEL, 8'h00, CHK_NONE,  8'h00, 1'b0},
    '{ROW_CFG,  REG_IMAGE_HEIGHT, 32'd2,    OP_PIXEL, 8'h00, CHK_NONE,  8'h00, 1'b0},
    '{ROW_BEAT, REG_MAX_WINDOW,   32'd0,    OP_PIXEL, 8'h00, CHK_MODEL, 8'h00, 1'b0},
    '{ROW_BEAT, REG_MAX_WINDOW,   32'd0,    OP_PIXEL, 8'hFF, CHK_MODEL, 8'h00, 1'b0},
    '{ROW_BEAT, REG_MAX_WINDOW,   32'd0,    OP_PIXEL, 8'h11, CHK_MODEL, 8'h00, 1'b0},
    '{ROW_BEAT, REG_MAX_WINDOW,   32'd0,    OP_PIXEL, 8'hC8, CHK_MODEL, 8'h00, 1'b0},
    '{ROW_BEAT, REG_MAX_WINDOW,   32'd0,    OP_FLUSH, 8'h00, CHK_MODEL, 8'h00, 1'b0},
    '{ROW_BEAT, REG_MAX_WINDOW,   32'd0,    OP_FLUSH, 8'h00, CHK_MODEL, 8'h00, 1'b0},
    '{ROW_BEAT, REG_MAX_WINDOW,   32'd0,    OP_FLUSH, 8'h00, CHK_MODEL, 8'h00, 1'b0},
    '{ROW_BEAT, REG_MAX_WINDOW,   32'd0,    OP_FLUSH, 8'h00, CHK_NONE,  8'h00, 1'b0},
    // width above range, single row
    '{ROW_CFG,  REG_MAX_WINDOW,   32'd7,    OP_PIXEL, 8'h00, CHK_NONE,  8'h00, 1'b0},
    '{ROW_CFG,  REG_IMAGE_WIDTH,  32'd2047, OP_PIXEL, 8'h00, CHK_NONE,  8'h00, 1'b0},
    '{ROW_CFG,  REG_IMAGE_HEIGHT, 32'd1,    OP_PIXEL, 8'h00, CHK_NONE,  8'h00, 1'b0},
    '{ROW_BEAT, REG_MAX_WINDOW,   32'd0,    OP_PIXEL, 8'hFE, CHK_MODEL, 8'h00, 1'b0},
    '{ROW_BEAT, REG_MAX_WINDOW,   32'd0,    OP_PIXEL, 8'h03, CHK_MODEL, 8'h00, 1'b0},
    '{ROW_BEAT, REG_MAX_WINDOW,   32'd0,    OP_PIXEL, 8'hFF, CHK_MODEL, 8'h00, 1'b0},
    '{ROW_BEAT, REG_MAX_WINDOW,   32'd0,    OP_PIXEL, 8'h00, CHK_MODEL, 8'h00, 1'b0},
    '{ROW_BEAT, REG_MAX_WINDOW,   32'd0,    OP_PIXEL, 8'h80, CHK_MODEL, 8'h00, 1'b0}
  };

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_stall;
  amf_in_t           in_data = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  amf_out_t          out_data;
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [DATA_W-1:0] pwdata = '0;
  logic [DATA_W-1:0] prdata;
  logic              pready;

  adaptive_median_filter_core dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  always begin
    clk_i = 1'b0;
    #2;
    clk_i = 1'b1;
    #2;
  end

  // predictor state
  logic [MW_W-1:0]  cfg_win = RST_MAX_WINDOW;
  logic [WID_W-1:0] cfg_width = RST_IMAGE_WIDTH;
  logic [ROW_W-1:0] cfg_height = RST_IMAGE_HEIGHT;
  logic [PIX_W-1:0] line_mem [LINES*MAX_WIDTH];
  int unsigned      in_col, in_row, out_col, out_row;

  amf_out_t pixel_q [$];
  int  err_cnt = 0;
  int  beats_in = 0;
  int  beats_out = 0;
  int  frames_done = 0;
  int  cfg_writes = 0;
  bit  quiet = 1'b0;
  bit  hold_go = 1'b0;
  bit  frame_end = 1'b0;

  function automatic int unsigned pix_at(int r, int c, int unsigned w, int unsigned h);
    if (r < 0 || c < 0 || r >= int'(h) || c >= int'(w)) return 0;
    return line_mem[(r % LINES) * MAX_WIDTH + c];
  endfunction

  function automatic logic [PIX_W-1:0] median_pick(int r, int c, int unsigned w,
                                                   int unsigned h);
    int unsigned mw, centre, zmed, zmin, zmax, n, v;
    int half, j;
    int unsigned vals [NCELL];
    mw = (cfg_win < 3) ? 3 : ((cfg_win > MAX_WINDOW) ? MAX_WINDOW : cfg_win);
    if (mw % 2 == 0) mw--;
    centre = pix_at(r, c, w, h);
    zmed = 0;
    for (int s = 3; s <= int'(mw); s += 2) begin
      half = s / 2;
      n = 0;
      for (int dr = -half; dr <= half; dr++)
        for (int dc = -half; dc <= half; dc++) begin
          vals[n] = pix_at(r + dr, c + dc, w, h);
          n++;
        end
      for (int i = 1; i < int'(n); i++) begin
        v = vals[i];
        j = i;
        while (j > 0 && vals[j-1] > v) begin
          vals[j] = vals[j-1];
          j--;
        end
        vals[j] = v;
      end
      zmin = vals[0];
      zmed = vals[(n - 1) / 2];
      zmax = vals[n - 1];
      if (zmin < zmed && zmed < zmax)
        return (zmin < centre && centre < zmax) ? centre[PIX_W-1:0] : zmed[PIX_W-1:0];
    end
    return zmed[PIX_W-1:0];
  endfunction

  task automatic filter_step(input amf_in_t b, output bit got, output amf_out_t res);
    int unsigned w, h, nr, nc;
    w = (cfg_width == 0) ? 1 : ((cfg_width > MAX_WIDTH) ? MAX_WIDTH : cfg_width);
    h = (cfg_height == 0) ? 1 : cfg_height;
    got = 1'b0;
    res = '0;
    if (b.opcode == OP_PIXEL && in_row < h) begin
      if (in_col < MAX_WIDTH) line_mem[(in_row % LINES) * MAX_WIDTH + in_col] = b.pixel_in;
      if (in_col + 1 >= w) begin
        in_col = 0;
        in_row++;
      end else begin
        in_col++;
      end
    end
    nr = out_row + RAD;
    if (nr > h - 1) nr = h - 1;
    nc = out_col + RAD;
    if (nc > w - 1) nc = w - 1;
    if (!(in_row >= h || in_row > nr || (in_row == nr && in_col > nc))) return;
    got = 1'b1;
    res.pixel_out = median_pick(int'(out_row), int'(out_col), w, h);
    res.frame_last = (out_row + 1 >= h && out_col + 1 >= w);
    if (res.frame_last) begin
      in_col = 0;
      in_row = 0;
      out_col = 0;
      out_row = 0;
      frame_end = 1'b1;
    end else if (out_col + 1 >= w) begin
      out_col = 0;
      out_row++;
    end else begin
      out_col++;
    end
  endtask

  // sender: optional idle burst, then hold the beat until accepted
  task automatic send_beat(input amf_in_t b, input chk_e chk, input amf_out_t given);
    bit got;
    amf_out_t res;
    if (!quiet && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk_i);
    end
    in_valid <= 1'b1;
    in_data  <= b;
    do @(posedge clk_i); while (in_stall);
    beats_in++;
    if (beats_in >= QUIET_AFTER) quiet = 1'b1;
    filter_step(b, got, res);
    if (chk == CHK_GIVEN) pixel_q.push_back(given);
    else if (chk == CHK_MODEL && got) pixel_q.push_back(res);
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (pixel_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);
  endtask

  task automatic reg_write(input logic [1:0] idx, input logic [31:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ADDR_W'({idx, 2'b00});
    pwdata  <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_MAX_WINDOW:   cfg_win = val[MW_W-1:0];
      REG_IMAGE_WIDTH:  cfg_width = val[WID_W-1:0];
      default:          cfg_height = val[ROW_W-1:0];
    endcase
    cfg_writes++;
  endtask

  function automatic logic [PIX_W-1:0] rand_pixel();
    case ($urandom_range(0, 9))
      0, 1, 2: return PIX_W'($urandom_range(0, 255));
      3, 4, 5: return $urandom_range(0, 1) ? 8'hFF : 8'h00;
      default: return PIX_W'($urandom_range(100, 103));
    endcase
  endfunction

  // one random geometry, then a frame that is mostly well formed
  task automatic run_frame(input int phase);
    amf_in_t b;
    int unsigned w, h, npix, stop_at, guard;
    int kind;
    kind = $urandom_range(0, 9);
    wait_idle();
    reg_write(REG_MAX_WINDOW, 32'($urandom_range(0, 7)));
    case (kind)
      0: begin
        w = $urandom_range(0, 1) ? 2047 : MAX_WIDTH;
        h = 1;
      end
      1: begin
        w = 1;
        h = 65535;
      end
      2: begin
        w = 0;
        h = 0;
      end
      default: begin
        w = $urandom_range(1, 9);
        h = $urandom_range(1, 7);
      end
    endcase
    reg_write(REG_IMAGE_WIDTH, 32'(w));
    reg_write(REG_IMAGE_HEIGHT, 32'(h));
    if (phase == 2) hold_go = 1'b1;
    frame_end = 1'b0;
    npix = (kind <= 1) ? $urandom_range(10, 16) : ((kind == 2) ? 3 : w * h);
    stop_at = ($urandom_range(0, 9) == 0) ? $urandom_range(0, npix) : npix;
    for (int unsigned i = 0; i < stop_at; i++) begin
      if ($urandom_range(0, 11) == 0) begin
        b.opcode = OP_FLUSH;
        b.pixel_in = PIX_W'($urandom_range(0, 255));
        send_beat(b, CHK_MODEL, '0);
      end
      b.opcode = OP_PIXEL;
      b.pixel_in = rand_pixel();
      send_beat(b, CHK_MODEL, '0);
    end
    if (kind <= 1 || stop_at != npix) return;
    // drain; pixels past the last input act as flush beats
    guard = 0;
    while (!frame_end && guard < 4000) begin
      if (in_row < ((cfg_height == 0) ? 1 : cfg_height) || $urandom_range(0, 2) == 0) begin
        b.opcode = OP_PIXEL;
        b.pixel_in = rand_pixel();
      end else begin
        b.opcode = OP_FLUSH;
        b.pixel_in = PIX_W'($urandom_range(0, 255));
      end
      send_beat(b, CHK_MODEL, '0);
      guard++;
    end
  endtask

  // receiver stall: random bursts, one long hold-off on request
  always begin
    @(posedge clk_i);
    if (hold_go) begin
      out_stall <= 1'b1;
      repeat (HOLD_CYCLES) @(posedge clk_i);
      out_stall <= 1'b0;
      hold_go = 1'b0;
    end else if (rst_ni && !quiet && $urandom_range(0, 9) == 0) begin
      out_stall <= 1'b1;
      repeat ($urandom_range(1, 11)) @(posedge clk_i);
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk_i) begin
    amf_out_t want;
    if (rst_ni && out_valid && !out_stall) begin
      beats_out++;
      if (out_data.frame_last) frames_done++;
      if (pixel_q.size() == 0) begin
        $error("unexpected output beat: pixel_out %0d frame_last %0d",
               out_data.pixel_out, out_data.frame_last);
        err_cnt++;
      end else begin
        want = pixel_q.pop_front();
        if (out_data.pixel_out !== want.pixel_out) begin
          $error("pixel_out mismatch: expected %0d, actual %0d",
                 want.pixel_out, out_data.pixel_out);
          err_cnt++;
        end
        if (out_data.frame_last !== want.frame_last) begin
          $error("frame_last mismatch: expected %0d, actual %0d",
                 want.frame_last, out_data.frame_last);
          err_cnt++;
        end
      end
    end
  end

  // watchdog on cycles with no beat on either side
  always @(posedge clk_i) begin
    int idle_cnt;
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cnt = 0;
    else idle_cnt++;
    if (idle_cnt == IDLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin
    amf_in_t  b;
    amf_out_t given;
    int phase;
    foreach (line_mem[i]) line_mem[i] = '0;
    in_col = 0;
    in_row = 0;
    out_col = 0;
    out_row = 0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    for (int i = 0; i < DIR_ROWS; i++) begin
      if (dir_tab[i].kind == ROW_CFG) begin
        wait_idle();
        reg_write(dir_tab[i].reg_idx, dir_tab[i].reg_val);
      end else begin
        b.opcode = dir_tab[i].op;
        b.pixel_in = dir_tab[i].pix;
        given.pixel_out = dir_tab[i].exp_pix;
        given.frame_last = dir_tab[i].exp_last;
        send_beat(b, dir_tab[i].chk, given);
      end
    end
    phase = 0;
    while (beats_in < NUM_BEATS) begin
      run_frame(phase);
      phase++;
    end
    in_valid <= 1'b0;
    while (pixel_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);
    $display("covered %0d input beats, %0d output beats, %0d frames, %0d register writes",
             beats_in, beats_out, frames_done, cfg_writes);
    if (err_cnt == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
